>>> sv/rvx_pkg.sv
// rvx_pkg: shared types and codes for the rv32im execute unit
`timescale 1ns / 1ps
package rvx_pkg;

  localparam int unsigned DIV_STEPS = 32;

  typedef enum logic [5:0] {
    ACT_ADD = 6'd0, ACT_SUB = 6'd1, ACT_AND = 6'd2, ACT_OR = 6'd3, ACT_XOR = 6'd4,
    ACT_SLL = 6'd5, ACT_SLT = 6'd6, ACT_SLTU = 6'd7, ACT_SRL = 6'd8, ACT_SRA = 6'd9,
    ACT_ADDI = 6'd10, ACT_ANDI = 6'd11, ACT_ORI = 6'd12, ACT_XORI = 6'd13,
    ACT_SLTI = 6'd14, ACT_SLTIU = 6'd15, ACT_SLLI = 6'd16, ACT_SRLI = 6'd17,
    ACT_SRAI = 6'd18, ACT_LW = 6'd19, ACT_LH = 6'd20, ACT_LHU = 6'd21, ACT_LB = 6'd22,
    ACT_LBU = 6'd23, ACT_SW = 6'd24, ACT_SH = 6'd25, ACT_SB = 6'd26, ACT_BEQ = 6'd27,
    ACT_BNE = 6'd28, ACT_BLT = 6'd29, ACT_BGE = 6'd30, ACT_BLTU = 6'd31,
    ACT_BGEU = 6'd32, ACT_JAL = 6'd33, ACT_JALR = 6'd34, ACT_LUI = 6'd35,
    ACT_AUIPC = 6'd36, ACT_ECALL = 6'd37, ACT_EBREAK = 6'd38, ACT_FENCE = 6'd39,
    ACT_CSRRW = 6'd40, ACT_CSRRS = 6'd41, ACT_CSRRC = 6'd42, ACT_CSRRWI = 6'd43,
    ACT_CSRRSI = 6'd44, ACT_CSRRCI = 6'd45, ACT_MUL = 6'd46, ACT_MULH = 6'd47,
    ACT_MULHSU = 6'd48, ACT_MULHU = 6'd49, ACT_DIV = 6'd50, ACT_DIVU = 6'd51,
    ACT_REM = 6'd52, ACT_REMU = 6'd53, ACT_MRET = 6'd54, ACT_INVALID = 6'd55
  } act_t;

  typedef enum logic [3:0] {
    MEM_NONE = 4'd0, MEM_LB = 4'd1, MEM_LBU = 4'd2, MEM_LH = 4'd3, MEM_LHU = 4'd4,
    MEM_LW = 4'd5, MEM_SB = 4'd6, MEM_SH = 4'd7, MEM_SW = 4'd8
  } mem_kind_t;

  typedef enum logic [2:0] {
    TRAP_NONE = 3'd0, TRAP_MISALIGN = 3'd1, TRAP_ILLEGAL = 3'd2,
    TRAP_BREAK = 3'd3, TRAP_ECALL = 3'd4
  } trap_t;

  typedef struct packed {
    logic [5:0]         action;
    logic [31:0]        rs1_value;
    logic [31:0]        rs2_value;
    logic [4:0]         rs1_index;
    logic [4:0]         rd_index;
    logic signed [31:0] immediate;
    logic [31:0]        pc_value;
    logic [31:0]        csr_old;
    logic [31:0]        raw_instr;
  } in_word_t;

  typedef struct packed {
    logic [4:0]  rd_number;
    logic        rd_write;
    logic [31:0] rd_value;
    logic        csr_update;
    logic [31:0] csr_value;
    logic [31:0] next_pc;
    logic [3:0]  mem_kind;
    logic [31:0] mem_address;
    logic [31:0] store_data;
    logic [2:0]  trap_cause;
    logic [31:0] trap_value;
  } out_word_t;

  typedef struct packed {
    out_word_t   res;
    logic        is_div;
    logic        want_rem;
    logic        neg_res;
    logic        by_zero;
    logic [31:0] dividend;
    logic [31:0] rem;
    logic [31:0] quo;
    logic [31:0] dvs;
  } stage_word_t;

endpackage

>>> sv/rvx_decode.sv
// rvx_decode: instruction execute logic for all but the divide steps
`timescale 1ns / 1ps
module rvx_decode import rvx_pkg::*; (
  input  in_word_t    in_word,
  input  logic [1:0]  misalign_mask,
  output stage_word_t stage_word
);

  logic [31:0] a, b, imm, pc, target, val, cval, next, addr, sdata, tval;
  logic        wr, cw, taken, sgn_div;
  logic [3:0]  mk;
  logic [2:0]  cause;
  logic signed [32:0] ma, mb;
  logic signed [65:0] prod;
  act_t        act;

  assign a   = in_word.rs1_value;
  assign b   = in_word.rs2_value;
  assign imm = in_word.immediate;
  assign pc  = in_word.pc_value;
  assign act = act_t'(in_word.action);

  assign ma   = {((act == ACT_MULH) || (act == ACT_MULHSU)) & a[31], a};
  assign mb   = {(act == ACT_MULH) & b[31], b};
  assign prod = ma * mb;
  assign sgn_div = (act == ACT_DIV) || (act == ACT_REM);

  always_comb begin
    wr = 1'b0; cw = 1'b0; taken = 1'b0;
    val = '0; cval = '0; target = '0;
    mk = MEM_NONE; addr = '0; sdata = '0; cause = TRAP_NONE; tval = '0;
    next = pc + 32'd4;
    unique case (act)
      ACT_ADD:   begin wr = 1'b1; val = a + b; end
      ACT_SUB:   begin wr = 1'b1; val = a - b; end
      ACT_AND:   begin wr = 1'b1; val = a & b; end
      ACT_OR:    begin wr = 1'b1; val = a | b; end
      ACT_XOR:   begin wr = 1'b1; val = a ^ b; end
      ACT_SLL:   begin wr = 1'b1; val = a << b[4:0]; end
      ACT_SLT:   begin wr = 1'b1; val = {31'd0, $signed(a) < $signed(b)}; end
      ACT_SLTU:  begin wr = 1'b1; val = {31'd0, a < b}; end
      ACT_SRL:   begin wr = 1'b1; val = a >> b[4:0]; end
      ACT_SRA:   begin wr = 1'b1; val = 32'($signed(a) >>> b[4:0]); end
      ACT_ADDI:  begin wr = 1'b1; val = a + imm; end
      ACT_ANDI:  begin wr = 1'b1; val = a & imm; end
      ACT_ORI:   begin wr = 1'b1; val = a | imm; end
      ACT_XORI:  begin wr = 1'b1; val = a ^ imm; end
      ACT_SLTI:  begin wr = 1'b1; val = {31'd0, $signed(a) < $signed(imm)}; end
      ACT_SLTIU: begin wr = 1'b1; val = {31'd0, a < imm}; end
      ACT_SLLI, ACT_SRLI: begin
        if (imm[31:5] != 27'd0) begin
          cause = TRAP_ILLEGAL; tval = in_word.raw_instr;
        end else begin
          wr = 1'b1;
          val = (act == ACT_SLLI) ? (a << imm[4:0]) : (a >> imm[4:0]);
        end
      end
      ACT_SRAI: begin
        if (imm[31:5] != 27'h20) begin
          cause = TRAP_ILLEGAL; tval = in_word.raw_instr;
        end else begin
          wr = 1'b1; val = 32'($signed(a) >>> imm[4:0]);
        end
      end
      ACT_LW:  begin mk = MEM_LW;  addr = a + imm; end
      ACT_LH:  begin mk = MEM_LH;  addr = a + imm; end
      ACT_LHU: begin mk = MEM_LHU; addr = a + imm; end
      ACT_LB:  begin mk = MEM_LB;  addr = a + imm; end
      ACT_LBU: begin mk = MEM_LBU; addr = a + imm; end
      ACT_SW:  begin mk = MEM_SW;  addr = a + imm; sdata = b; end
      ACT_SH:  begin mk = MEM_SH;  addr = a + imm; sdata = b; end
      ACT_SB:  begin mk = MEM_SB;  addr = a + imm; sdata = b; end
      ACT_BEQ:  begin taken = (a == b); target = pc + imm; end
      ACT_BNE:  begin taken = (a != b); target = pc + imm; end
      ACT_BLT:  begin taken = $signed(a) < $signed(b); target = pc + imm; end
      ACT_BGE:  begin taken = !($signed(a) < $signed(b)); target = pc + imm; end
      ACT_BLTU: begin taken = (a < b); target = pc + imm; end
      ACT_BGEU: begin taken = (a >= b); target = pc + imm; end
      ACT_JAL: begin
        taken = 1'b1; target = pc + imm; wr = 1'b1; val = pc + 32'd4;
      end
      ACT_JALR: begin
        taken = 1'b1; target = (a + imm) & ~32'd1; wr = 1'b1; val = pc + 32'd4;
      end
      ACT_LUI:    begin wr = 1'b1; val = imm; end
      ACT_AUIPC:  begin wr = 1'b1; val = pc + imm; end
      ACT_ECALL:  cause = TRAP_ECALL;
      ACT_EBREAK: cause = TRAP_BREAK;
      ACT_FENCE, ACT_MRET: ;
      ACT_CSRRW: begin wr = 1'b1; val = in_word.csr_old; cw = 1'b1; cval = a; end
      ACT_CSRRS: begin
        wr = 1'b1; val = in_word.csr_old;
        cw = (in_word.rs1_index != 5'd0); cval = in_word.csr_old | a;
      end
      ACT_CSRRC: begin
        wr = 1'b1; val = in_word.csr_old;
        cw = (in_word.rs1_index != 5'd0); cval = in_word.csr_old & ~a;
      end
      ACT_CSRRWI: begin
        wr = 1'b1; val = in_word.csr_old; cw = 1'b1; cval = {27'd0, in_word.rs1_index};
      end
      ACT_CSRRSI: begin
        wr = 1'b1; val = in_word.csr_old;
        cw = (in_word.rs1_index != 5'd0);
        cval = in_word.csr_old | {27'd0, in_word.rs1_index};
      end
      ACT_CSRRCI: begin
        wr = 1'b1; val = in_word.csr_old;
        cw = (in_word.rs1_index != 5'd0);
        cval = in_word.csr_old & ~{27'd0, in_word.rs1_index};
      end
      ACT_MUL:   begin wr = 1'b1; val = prod[31:0]; end
      ACT_MULH, ACT_MULHSU, ACT_MULHU: begin wr = 1'b1; val = prod[63:32]; end
      ACT_DIV, ACT_DIVU, ACT_REM, ACT_REMU: wr = 1'b1;
      default: begin cause = TRAP_ILLEGAL; tval = in_word.raw_instr; end
    endcase

    if (taken) begin
      if ((target[1:0] & misalign_mask) != 2'd0) begin
        cause = TRAP_MISALIGN; tval = target;
      end else begin
        next = target;
      end
    end
    if (cause != TRAP_NONE) begin
      wr = 1'b0; cw = 1'b0; mk = MEM_NONE; addr = '0; sdata = '0; next = '0;
    end
    if (in_word.rd_index == 5'd0) wr = 1'b0;
    if (!wr) val = '0;
    if (!cw) cval = '0;
  end

  always_comb begin
    stage_word.res.rd_number   = in_word.rd_index;
    stage_word.res.rd_write    = wr;
    stage_word.res.rd_value    = val;
    stage_word.res.csr_update  = cw;
    stage_word.res.csr_value   = cval;
    stage_word.res.next_pc     = next;
    stage_word.res.mem_kind    = mk;
    stage_word.res.mem_address = addr;
    stage_word.res.store_data  = sdata;
    stage_word.res.trap_cause  = cause;
    stage_word.res.trap_value  = tval;
    stage_word.is_div   = (act == ACT_DIV) || (act == ACT_DIVU) ||
                          (act == ACT_REM) || (act == ACT_REMU);
    stage_word.want_rem = (act == ACT_REM) || (act == ACT_REMU);
    stage_word.neg_res  = sgn_div & ((act == ACT_DIV) ? (a[31] ^ b[31]) : a[31]);
    stage_word.by_zero  = (b == 32'd0);
    stage_word.dividend = a;
    stage_word.rem      = '0;
    stage_word.quo      = (sgn_div && a[31]) ? (~a + 32'd1) : a;
    stage_word.dvs      = (sgn_div && b[31]) ? (~b + 32'd1) : b;
  end

endmodule

>>> sv/rvx_div_cell.sv
// rvx_div_cell: one restoring divide step and pipeline register
`timescale 1ns / 1ps
module rvx_div_cell import rvx_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        in_valid,
  input  stage_word_t in_word,
  output logic        out_valid,
  output stage_word_t out_word
);

  logic        valid_r;
  stage_word_t word_r, word_nxt;
  logic [32:0] tmp;
  logic [33:0] diff;
  logic        ge;

  assign tmp  = {in_word.rem, in_word.quo[31]};
  assign diff = {1'b0, tmp} - {2'b00, in_word.dvs};
  assign ge   = !diff[33];

  always_comb begin
    word_nxt     = in_word;
    word_nxt.rem = ge ? diff[31:0] : tmp[31:0];
    word_nxt.quo = {in_word.quo[30:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      word_r <= word_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_word  = word_r;

endmodule

>>> sv/rv32im_execute_unit.sv
// rv32im_execute_unit: pipelined rv32im execute stage with a divide cell chain
//   channel  direction  handshake            word
//   in_      input      in_valid / in_ready  in_word_t
//   out_     output     out_valid/ out_ready out_word_t
//   cfg_     input      cfg_wr_en            misalign_mask
// one word per cycle while out_ready is high; stages: input register, execute
// register, 32 divide cells (one quotient bit each), output register
// a stalled output fills bubbles first; in_ready falls only when every stage is full
// synchronous active-low reset clears valids and sets misalign_mask to 3
`timescale 1ns / 1ps
module rv32im_execute_unit import rvx_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_word_t   in_word,
  output logic       out_valid,
  input  logic       out_ready,
  output out_word_t  out_word,
  input  logic       cfg_wr_en,
  input  logic [1:0] cfg_wr_data
);

  logic [1:0]  mask_r;
  logic        in_valid_r, dec_valid_r, out_valid_r;
  in_word_t    in_r;
  stage_word_t dec_nxt, dec_r, last_w;
  out_word_t   out_r, out_nxt;
  logic        adv_in, adv_dec, adv_out;
  logic [DIV_STEPS-1:0] adv_c, cv;
  stage_word_t cw [DIV_STEPS];
  logic [31:0] q_fix, r_fix;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= 2'd3;
    end else if (cfg_wr_en) begin
      mask_r <= cfg_wr_data;
    end
  end

  assign adv_out = !out_valid_r || out_ready;
  assign adv_c[DIV_STEPS-1] = !cv[DIV_STEPS-1] || adv_out;
  genvar g;
  generate
    for (g = 0; g < DIV_STEPS - 1; g++) begin : g_adv
      assign adv_c[g] = !cv[g] || adv_c[g+1];
    end
  endgenerate
  assign adv_dec  = !dec_valid_r || adv_c[0];
  assign adv_in   = !in_valid_r || adv_dec;
  assign in_ready = adv_in;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      dec_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv_in)  in_valid_r  <= in_valid;
      if (adv_dec) dec_valid_r <= in_valid_r;
      if (adv_out) out_valid_r <= cv[DIV_STEPS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv_in)  in_r  <= in_word;
    if (adv_dec) dec_r <= dec_nxt;
    if (adv_out) out_r <= out_nxt;
  end

  rvx_decode u_decode (
    .in_word      (in_r),
    .misalign_mask(mask_r),
    .stage_word   (dec_nxt)
  );

  generate
    for (g = 0; g < DIV_STEPS; g++) begin : g_cell
      rvx_div_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv_c[g]),
        .in_valid ((g == 0) ? dec_valid_r : cv[(g == 0) ? 0 : g-1]),
        .in_word  ((g == 0) ? dec_r : cw[(g == 0) ? 0 : g-1]),
        .out_valid(cv[g]),
        .out_word (cw[g])
      );
    end
  endgenerate

  assign last_w = cw[DIV_STEPS-1];
  assign q_fix  = last_w.neg_res ? (~last_w.quo + 32'd1) : last_w.quo;
  assign r_fix  = last_w.neg_res ? (~last_w.rem + 32'd1) : last_w.rem;

  always_comb begin
    out_nxt = last_w.res;
    if (last_w.is_div && last_w.res.rd_write) begin
      if (last_w.by_zero) begin
        out_nxt.rd_value = last_w.want_rem ? last_w.dividend : 32'hFFFF_FFFF;
      end else begin
        out_nxt.rd_value = last_w.want_rem ? r_fix : q_fix;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_r;

`ifndef NO_ASSERTIONS
  a_trap_no_effect: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_word.trap_cause != TRAP_NONE) |->
      !out_word.rd_write && !out_word.csr_update && (out_word.mem_kind == MEM_NONE))
    else $error("trap with side effect");
  a_no_x0_write: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.rd_write |-> (out_word.rd_number != 5'd0))
    else $error("write to x0");
  a_full_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && in_valid_r && dec_valid_r && (&cv))
    else $error("input blocked with a bubble in the pipeline");
`endif

endmodule
